/* design/cpu_alu_with_flags_macros.svh */
`ifndef CPU_ALU_WITH_FLAGS_MACROS_SVH
`define CPU_ALU_WITH_FLAGS_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CAF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cpu_alu_with_flags: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CAF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cpu_alu_with_flags: next-cycle check failed");

`endif

/* design/cpualu_pkg.sv */
`default_nettype none

package cpualu_pkg;

   typedef enum logic [4:0] {
      OP_ADD    = 5'd0,
      OP_ADC    = 5'd1,
      OP_SUB    = 5'd2,
      OP_SBC    = 5'd3,
      OP_CP     = 5'd4,
      OP_AND    = 5'd5,
      OP_OR     = 5'd6,
      OP_XOR    = 5'd7,
      OP_INC    = 5'd8,
      OP_DEC    = 5'd9,
      OP_RLC    = 5'd10,
      OP_RL     = 5'd11,
      OP_RRC    = 5'd12,
      OP_RR     = 5'd13,
      OP_SLA    = 5'd14,
      OP_SLL    = 5'd15,
      OP_SRA    = 5'd16,
      OP_SRL    = 5'd17,
      OP_BIT    = 5'd18,
      OP_BITIDX = 5'd19,
      OP_SET    = 5'd20,
      OP_RES    = 5'd21,
      OP_DAA    = 5'd22,
      OP_ADD16  = 5'd23,
      OP_ADC16  = 5'd24,
      OP_SBC16  = 5'd25,
      OP_SUB16  = 5'd26,
      OP_COND   = 5'd27
   } op_type;

   typedef enum logic [3:0] {
      CC_NZ     = 4'd0,
      CC_Z      = 4'd1,
      CC_NC     = 4'd2,
      CC_C      = 4'd3,
      CC_PO     = 4'd4,
      CC_PE     = 4'd5,
      CC_P      = 4'd6,
      CC_M      = 4'd7,
      CC_ALWAYS = 4'd8
   } cond_type;

   localparam int unsigned FLAG_S  = 7;
   localparam int unsigned FLAG_Z  = 6;
   localparam int unsigned FLAG_5  = 5;
   localparam int unsigned FLAG_H  = 4;
   localparam int unsigned FLAG_3  = 3;
   localparam int unsigned FLAG_PV = 2;
   localparam int unsigned FLAG_N  = 1;
   localparam int unsigned FLAG_C  = 0;

   localparam logic [7:0] DAA_LIMIT    = 8'h99;
   localparam logic [7:0] DAA_CORR_HI  = 8'h60;
   localparam logic [7:0] DAA_CORR_LO  = 8'h06;
   localparam logic [3:0] DAA_NIB_MAX  = 4'd9;
   localparam logic [7:0] INC_OVF_VAL  = 8'h7F;
   localparam logic [7:0] DEC_OVF_VAL  = 8'h80;

   typedef struct packed {
      logic [4:0]  op;
      logic [7:0]  acc;
      logic [7:0]  flags_in;
      logic [7:0]  byte_operand;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [2:0]  bit_pos;
      logic [3:0]  cond_code;
      logic        full_flags;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [7:0]  flags_out;
      logic        cond_true;
   } rsp_type;

   function automatic logic even_parity(input logic [7:0] v);
      return ~(^v);
   endfunction

endpackage

`default_nettype wire

/* design/cpu_alu_with_flags.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_data (req_type)
// rsp       out        rsp_valid/rsp_ready   rsp_data (rsp_type)
//
// One transaction per cycle is sustained unless the result is stalled.
// The input register feeds the ALU logic, whose output is captured in the result register.
// Reset clears both valid bits; payload registers are not reset.
// A stalled result holds the result register, and the input register then fills and
// drops req_ready only when both stages hold a transaction.
`default_nettype none
`include "cpu_alu_with_flags_macros.svh"

module cpu_alu_with_flags
   import cpualu_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_data
);

   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_data_ff;
   req_type s1_data_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   rsp_type alu_rsp;
   logic    s1_ready;
   logic    s2_ready;

   cpualu_core u_core (
      .req_i (s1_data_ff),
      .rsp_o (alu_rsp)
   );

   always_comb begin
      s2_ready = ~rsp_valid_ff | rsp_ready;
      s1_ready = ~s1_valid_ff | s2_ready;
   end

   always_comb begin
      s1_valid_in  = s1_ready ? req_valid : s1_valid_ff;
      s1_data_in   = (s1_ready && req_valid) ? req_data : s1_data_ff;
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = (s2_ready && s1_valid_ff) ? alu_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = s1_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CAF_ASSERT_NEXT(a_req_lands, req_valid && req_ready, s1_valid_ff)
   `CAF_ASSERT_NEXT(a_stage_moves, s1_valid_ff && s2_ready, rsp_valid_ff)
   `CAF_ASSERT_NOW(a_full_stalls, s1_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)
   `CAF_ASSERT_NOW(a_set_keeps_flags, s1_valid_ff && s1_data_ff.op == OP_SET,
                   alu_rsp.flags_out == s1_data_ff.flags_in)

endmodule

`default_nettype wire

/* design/cpualu_core.sv */
`default_nettype none

module cpualu_core
   import cpualu_pkg::*;
(
   input  req_type req_i,
   output rsp_type rsp_o
);

   logic [7:0]  a;
   logic [7:0]  v;
   logic [7:0]  fin;
   logic        cin;

   logic        ar_sub;
   logic        ar_cin;
   logic [8:0]  ar_sum;
   logic [4:0]  ar_half;
   logic        ar_ov;

   logic [7:0]  logic_r;
   logic [7:0]  incdec_r;

   logic        sh_left;
   logic        sh_out;
   logic        sh_fill;
   logic [7:0]  sh_r;

   logic        bit_set;
   logic [7:0]  bit_mask;

   logic [7:0]  daa_corr;
   logic        daa_carry;
   logic [7:0]  daa_r;

   logic        w_sub;
   logic        w_wc;
   logic        w_cin;
   logic [16:0] w_sum;
   logic [12:0] w_half;
   logic        w_ov;

   logic [7:0]  f;
   logic [15:0] r;
   logic        cond;

   assign a   = req_i.acc;
   assign v   = req_i.byte_operand;
   assign fin = req_i.flags_in;
   assign cin = fin[FLAG_C];

   // Eight-bit add and subtract, shared by add, adc, sub, sbc and cp.
   assign ar_sub = (req_i.op == OP_SUB) || (req_i.op == OP_SBC) || (req_i.op == OP_CP);
   assign ar_cin = ((req_i.op == OP_ADC) || (req_i.op == OP_SBC)) ? cin : 1'b0;
   assign ar_sum = ar_sub ? ({1'b0, a} - {1'b0, v} - {8'd0, ar_cin})
                          : ({1'b0, a} + {1'b0, v} + {8'd0, ar_cin});
   assign ar_half = ar_sub ? ({1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ar_cin})
                           : ({1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ar_cin});
   assign ar_ov = ar_sub ? ((a[7] ^ v[7]) & (a[7] ^ ar_sum[7]))
                         : (~(a[7] ^ v[7]) & (a[7] ^ ar_sum[7]));

   always_comb begin
      case (req_i.op)
         OP_AND:  logic_r = a & v;
         OP_OR:   logic_r = a | v;
         default: logic_r = a ^ v;
      endcase
   end

   assign incdec_r = (req_i.op == OP_DEC) ? (v - 8'd1) : (v + 8'd1);

   assign sh_left = (req_i.op == OP_RLC) || (req_i.op == OP_RL) ||
                    (req_i.op == OP_SLA) || (req_i.op == OP_SLL);
   assign sh_out  = sh_left ? v[7] : v[0];

   always_comb begin
      case (req_i.op)
         OP_RLC:  sh_fill = sh_out;
         OP_RL:   sh_fill = cin;
         OP_RRC:  sh_fill = sh_out;
         OP_RR:   sh_fill = cin;
         OP_SLL:  sh_fill = 1'b1;
         OP_SRA:  sh_fill = v[7];
         default: sh_fill = 1'b0;
      endcase
   end

   assign sh_r = sh_left ? {v[6:0], sh_fill} : {sh_fill, v[7:1]};

   assign bit_set  = v[req_i.bit_pos];
   assign bit_mask = 8'h01 << req_i.bit_pos;

   assign daa_carry = (a > DAA_LIMIT) || cin;
   assign daa_corr  = (daa_carry ? DAA_CORR_HI : 8'h00) |
                      (((a[3:0] > DAA_NIB_MAX) || fin[FLAG_H]) ? DAA_CORR_LO : 8'h00);
   assign daa_r     = fin[FLAG_N] ? (a - daa_corr) : (a + daa_corr);

   // Sixteen-bit add and subtract.
   assign w_sub  = (req_i.op == OP_SBC16) || (req_i.op == OP_SUB16);
   assign w_wc   = (req_i.op == OP_ADC16) || (req_i.op == OP_SBC16);
   assign w_cin  = w_wc ? cin : 1'b0;
   assign w_sum  = w_sub ? ({1'b0, req_i.word_a} - {1'b0, req_i.word_b} - {16'd0, w_cin})
                         : ({1'b0, req_i.word_a} + {1'b0, req_i.word_b} + {16'd0, w_cin});
   assign w_half = w_sub ? ({1'b0, req_i.word_a[11:0]} - {1'b0, req_i.word_b[11:0]}
                            - {12'd0, w_cin})
                         : ({1'b0, req_i.word_a[11:0]} + {1'b0, req_i.word_b[11:0]}
                            + {12'd0, w_cin});
   assign w_ov = w_sub ? ((req_i.word_a[15] ^ req_i.word_b[15]) &
                          (req_i.word_a[15] ^ w_sum[15]))
                       : (~(req_i.word_a[15] ^ req_i.word_b[15]) &
                          (req_i.word_a[15] ^ w_sum[15]));

   always_comb begin
      f = fin;
      r = 16'h0000;
      case (req_i.op)
         OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP: begin
            f[FLAG_N]  = ar_sub;
            f[FLAG_H]  = ar_half[4];
            f[FLAG_S]  = ar_sum[7];
            f[FLAG_C]  = ar_sum[8];
            f[FLAG_Z]  = (ar_sum[7:0] == 8'h00);
            f[FLAG_PV] = ar_ov;
            if (req_i.op == OP_CP) begin
               f[FLAG_5] = v[5];
               f[FLAG_3] = v[3];
               r = {8'h00, a};
            end else begin
               f[FLAG_5] = ar_sum[5];
               f[FLAG_3] = ar_sum[3];
               r = {8'h00, ar_sum[7:0]};
            end
         end
         OP_AND, OP_OR, OP_XOR: begin
            f[FLAG_S]  = logic_r[7];
            f[FLAG_Z]  = (logic_r == 8'h00);
            f[FLAG_PV] = even_parity(logic_r);
            f[FLAG_H]  = (req_i.op == OP_AND);
            f[FLAG_N]  = 1'b0;
            f[FLAG_C]  = 1'b0;
            f[FLAG_5]  = logic_r[5];
            f[FLAG_3]  = logic_r[3];
            r = {8'h00, logic_r};
         end
         OP_INC, OP_DEC: begin
            if (req_i.op == OP_DEC) begin
               f[FLAG_PV] = (v == DEC_OVF_VAL);
               f[FLAG_H]  = (incdec_r[3:0] == 4'hF);
            end else begin
               f[FLAG_PV] = (v == INC_OVF_VAL);
               f[FLAG_H]  = (incdec_r[3:0] == 4'h0);
            end
            f[FLAG_S] = incdec_r[7];
            f[FLAG_Z] = (incdec_r == 8'h00);
            f[FLAG_N] = (req_i.op == OP_DEC);
            f[FLAG_5] = incdec_r[5];
            f[FLAG_3] = incdec_r[3];
            r = {8'h00, incdec_r};
         end
         OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SLL, OP_SRA, OP_SRL: begin
            f[FLAG_C] = sh_out;
            f[FLAG_H] = 1'b0;
            f[FLAG_N] = 1'b0;
            f[FLAG_5] = sh_r[5];
            f[FLAG_3] = sh_r[3];
            if ((req_i.op >= OP_SLA) || req_i.full_flags) begin
               f[FLAG_S]  = sh_r[7];
               f[FLAG_Z]  = (sh_r == 8'h00);
               f[FLAG_PV] = even_parity(sh_r);
            end
            r = {8'h00, sh_r};
         end
         OP_BIT, OP_BITIDX: begin
            f[FLAG_Z]  = ~bit_set;
            f[FLAG_PV] = ~bit_set;
            f[FLAG_H]  = 1'b1;
            f[FLAG_N]  = 1'b0;
            f[FLAG_S]  = (req_i.bit_pos == 3'd7) && bit_set;
            if (req_i.op == OP_BIT) begin
               f[FLAG_5] = v[5];
               f[FLAG_3] = v[3];
            end else begin
               f[FLAG_5] = req_i.word_a[13];
               f[FLAG_3] = req_i.word_a[11];
            end
            r = {8'h00, v};
         end
         OP_SET: begin
            r = {8'h00, v | bit_mask};
         end
         OP_RES: begin
            r = {8'h00, v & ~bit_mask};
         end
         OP_DAA: begin
            f[FLAG_H]  = a[4] ^ daa_r[4];
            f[FLAG_C]  = daa_carry;
            f[FLAG_S]  = daa_r[7];
            f[FLAG_Z]  = (daa_r == 8'h00);
            f[FLAG_PV] = even_parity(daa_r);
            f[FLAG_5]  = daa_r[5];
            f[FLAG_3]  = daa_r[3];
            r = {8'h00, daa_r};
         end
         OP_ADD16, OP_ADC16, OP_SBC16, OP_SUB16: begin
            f[FLAG_H] = w_half[12];
            f[FLAG_C] = w_sum[16];
            if (w_wc || w_sub) begin
               f[FLAG_PV] = w_ov;
               f[FLAG_S]  = w_sum[15];
               f[FLAG_Z]  = (w_sum[15:0] == 16'h0000);
            end
            f[FLAG_N] = w_sub;
            f[FLAG_5] = w_sum[13];
            f[FLAG_3] = w_sum[11];
            r = w_sum[15:0];
         end
         default: begin
            f = fin;
            r = 16'h0000;
         end
      endcase
   end

   always_comb begin
      case (req_i.cond_code)
         CC_NZ:     cond = ~fin[FLAG_Z];
         CC_Z:      cond = fin[FLAG_Z];
         CC_NC:     cond = ~fin[FLAG_C];
         CC_C:      cond = fin[FLAG_C];
         CC_PO:     cond = ~fin[FLAG_PV];
         CC_PE:     cond = fin[FLAG_PV];
         CC_P:      cond = ~fin[FLAG_S];
         CC_M:      cond = fin[FLAG_S];
         CC_ALWAYS: cond = 1'b1;
         default:   cond = 1'b0;
      endcase
   end

   assign rsp_o.result    = r;
   assign rsp_o.flags_out = f;
   assign rsp_o.cond_true = cond;

endmodule

`default_nettype wire
